// ----- sv/wdlbr_pkg.sv -----
// shared types, constants and permutation tables for the wav to dvd lpcm byte reorder
`timescale 1ns / 1ps

package wdlbr_pkg;

  localparam int ByteW    = 8;
  localparam int GroupMax = 12;
  localparam int IdxW     = $clog2(GroupMax + 1);

  typedef enum logic [1:0] {
    FMT_PASS     = 2'd0,
    FMT_16       = 2'd1,
    FMT_24_MONO  = 2'd2,
    FMT_24_MULTI = 2'd3
  } fmt_e;

  // one group handed from the collector to the emitter
  typedef struct packed {
    logic [IdxW-1:0] count;
    logic            unswapped;
    logic            stream_end;
  } load_t;

  function automatic logic [IdxW-1:0] group_size(fmt_e fmt);
    logic [IdxW-1:0] gsz;
    unique case (fmt)
      FMT_PASS:     gsz = IdxW'(1);
      FMT_16:       gsz = IdxW'(2);
      FMT_24_MONO:  gsz = IdxW'(6);
      FMT_24_MULTI: gsz = IdxW'(12);
      default:      gsz = IdxW'(1);
    endcase
    return gsz;
  endfunction

  // source position in the collected group for output position k
  function automatic logic [IdxW-1:0] perm_src(fmt_e fmt, logic [IdxW-1:0] k);
    logic [IdxW-1:0] src;
    src = '0;
    unique case (fmt)
      FMT_PASS: src = '0;
      FMT_16: begin
        if (k == IdxW'(0)) src = IdxW'(1);
        else               src = IdxW'(0);
      end
      FMT_24_MONO: begin
        unique case (k)
          IdxW'(0): src = IdxW'(2);
          IdxW'(1): src = IdxW'(1);
          IdxW'(2): src = IdxW'(5);
          IdxW'(3): src = IdxW'(4);
          IdxW'(4): src = IdxW'(0);
          IdxW'(5): src = IdxW'(3);
          default:  src = '0;
        endcase
      end
      FMT_24_MULTI: begin
        unique case (k)
          IdxW'(0):  src = IdxW'(2);
          IdxW'(1):  src = IdxW'(1);
          IdxW'(2):  src = IdxW'(5);
          IdxW'(3):  src = IdxW'(4);
          IdxW'(4):  src = IdxW'(8);
          IdxW'(5):  src = IdxW'(7);
          IdxW'(6):  src = IdxW'(11);
          IdxW'(7):  src = IdxW'(10);
          IdxW'(8):  src = IdxW'(0);
          IdxW'(9):  src = IdxW'(3);
          IdxW'(10): src = IdxW'(6);
          IdxW'(11): src = IdxW'(9);
          default:   src = '0;
        endcase
      end
      default: src = '0;
    endcase
    return src;
  endfunction

endpackage

// ----- sv/wav_to_dvd_lpcm_byte_reorder.sv -----
// top level: wav pcm to dvd lpcm byte reorder with group collector and result buffer
`timescale 1ns / 1ps
// the first byte of a group is valid in the cycle after the transfer that completes it
// throughput: one input byte and one output byte per cycle while out_stall_i is low; a group drains
//   while the next group collects, so the only input stall is a completing or stream-end byte
//   meeting a result buffer that is still draining
// reset: rst_ni low clears the format (pass-through) and the fill count, and empties the result buffer

module wav_to_dvd_lpcm_byte_reorder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_wdata_i,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [wdlbr_pkg::ByteW-1:0]   in_byte_i,
  input  logic                          stream_end_i,
  // output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [wdlbr_pkg::ByteW-1:0]   out_byte_o,
  output logic                          run_last_o,
  output logic                          stream_last_o,
  output logic                          unswapped_o
);

  // format register
  wdlbr_pkg::fmt_e                                       fmt_q;

  // collector: bytes of the group so far, last slot is never stored
  logic [wdlbr_pkg::IdxW-1:0]                            fill_q;
  logic [wdlbr_pkg::GroupMax-2:0][wdlbr_pkg::ByteW-1:0]  buf_q;

  logic [wdlbr_pkg::GroupMax-1:0][wdlbr_pkg::ByteW-1:0]  group;
  logic [wdlbr_pkg::GroupMax-1:0][wdlbr_pkg::ByteW-1:0]  load_bytes;
  logic [wdlbr_pkg::IdxW-1:0]                            gsz;
  logic [wdlbr_pkg::IdxW-1:0]                            fill_inc;
  logic                                                  completes;
  logic                                                  need_load;
  logic                                                  emit_free;
  logic                                                  in_xfer;
  wdlbr_pkg::load_t                                      load;

  assign gsz       = wdlbr_pkg::group_size(fmt_q);
  assign fill_inc  = wdlbr_pkg::IdxW'(fill_q + wdlbr_pkg::IdxW'(1));
  assign completes = (fill_inc == gsz);
  // a full group or a stream end both hand something to the result buffer
  assign need_load = completes || stream_end_i;
  assign in_stall_o = need_load && !emit_free;
  assign in_xfer    = in_valid_i && !in_stall_o;

  // the current byte sits at the fill position of the group view
  always_comb begin
    for (int k = 0; k < wdlbr_pkg::GroupMax - 1; k++) begin
      group[k] = (fill_q == wdlbr_pkg::IdxW'(k)) ? in_byte_i : buf_q[k];
    end
    group[wdlbr_pkg::GroupMax-1] = in_byte_i;
  end

  // full group goes out permuted, a trailing partial group in arrival order
  always_comb begin
    for (int k = 0; k < wdlbr_pkg::GroupMax; k++) begin
      if (completes) begin
        load_bytes[k] = group[wdlbr_pkg::perm_src(fmt_q, wdlbr_pkg::IdxW'(k))];
      end else begin
        load_bytes[k] = group[k];
      end
    end
    load.count      = completes ? gsz : fill_inc;
    load.unswapped  = !completes;
    load.stream_end = stream_end_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q  <= wdlbr_pkg::FMT_PASS;
      fill_q <= '0;
    end else if (cfg_we_i) begin
      // a format change drops any partial group
      fmt_q  <= wdlbr_pkg::fmt_e'(cfg_wdata_i);
      fill_q <= '0;
    end else if (in_xfer) begin
      if (need_load) begin
        fill_q <= '0;
      end else begin
        fill_q <= fill_inc;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < wdlbr_pkg::GroupMax - 1; k++) begin
      if (in_xfer && !need_load && fill_q == wdlbr_pkg::IdxW'(k)) begin
        buf_q[k] <= in_byte_i;
      end
    end
  end

  wdlbr_emit u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_valid_i  (in_xfer && need_load),
    .load_i        (load),
    .load_bytes_i  (load_bytes),
    .free_o        (emit_free),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .run_last_o    (run_last_o),
    .stream_last_o (stream_last_o),
    .unswapped_o   (unswapped_o)
  );

endmodule

// ----- sv/wdlbr_emit.sv -----
// result buffer that holds one group (reordered, or partial in arrival order) and drains it a byte per transfer
`timescale 1ns / 1ps

module wdlbr_emit (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  logic                                            load_valid_i,
  input  wdlbr_pkg::load_t                                load_i,
  input  logic [wdlbr_pkg::GroupMax-1:0][wdlbr_pkg::ByteW-1:0] load_bytes_i,
  output logic                                            free_o,
  output logic                                            out_valid_o,
  input  logic                                            out_stall_i,
  output logic [wdlbr_pkg::ByteW-1:0]                     out_byte_o,
  output logic                                            run_last_o,
  output logic                                            stream_last_o,
  output logic                                            unswapped_o
);

  logic                                                   busy_q;
  logic [wdlbr_pkg::IdxW-1:0]                             rd_idx_q;
  wdlbr_pkg::load_t                                       info_q;
  logic [wdlbr_pkg::GroupMax-1:0][wdlbr_pkg::ByteW-1:0]   data_q;
  logic                                                   last_byte;
  logic                                                   out_xfer;

  assign last_byte = (rd_idx_q == wdlbr_pkg::IdxW'(info_q.count - wdlbr_pkg::IdxW'(1)));
  assign out_xfer  = busy_q && !out_stall_i;
  assign free_o    = !busy_q || (out_xfer && last_byte);

  assign out_valid_o   = busy_q;
  assign out_byte_o    = data_q[rd_idx_q];
  assign run_last_o    = last_byte;
  assign stream_last_o = last_byte && info_q.stream_end;
  assign unswapped_o   = info_q.unswapped;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      rd_idx_q <= '0;
      info_q   <= '0;
    end else if (load_valid_i) begin
      busy_q   <= 1'b1;
      rd_idx_q <= '0;
      info_q   <= load_i;
    end else if (out_xfer) begin
      if (last_byte) begin
        busy_q <= 1'b0;
      end else begin
        rd_idx_q <= wdlbr_pkg::IdxW'(rd_idx_q + wdlbr_pkg::IdxW'(1));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_valid_i) begin
      data_q <= load_bytes_i;
    end
  end

endmodule

// ----- sv/wdlbr_checker.sv -----
// port-level checks for the wav to dvd lpcm byte reorder, bound to the top level
`timescale 1ns / 1ps

module wdlbr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_byte_o,
  input logic       run_last_o,
  input logic       stream_last_o,
  input logic       unswapped_o
);

  // a stalled result holds its byte
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o))
    else $error("stalled output byte changed");

  // stream end only ever closes a run
  a_stream_last_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && stream_last_o |-> run_last_o)
    else $error("stream_last without run_last");

  // a partial group is only flushed at stream end
  a_unswapped_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && unswapped_o && run_last_o |-> stream_last_o)
    else $error("unswapped run not at stream end");

  // the input only backs up behind a result buffer that holds something
  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty result buffer");

  // nothing comes out while reset is held
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("output valid during reset");

endmodule

bind wav_to_dvd_lpcm_byte_reorder wdlbr_checker u_wdlbr_checker (.*);

// ----- test/lpcm_order_checker.sv -----
// checker that predicts the dvd lpcm byte order and compares it with the output transfers
`timescale 1ns / 1ps

module lpcm_order_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_wdata_i,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [7:0] in_byte_i,
  input  logic       stream_end_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [7:0] out_byte_i,
  input  logic       run_last_i,
  input  logic       stream_last_i,
  input  logic       unswapped_i,
  output int         err_count_o,
  output int         pending_o
);

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       stream_last;
    logic       unswapped;
  } lpcm_byte_t;

  // source slot per output slot, slot 0 in the low nibble
  localparam logic [7:0]  SRC_16    = {4'd0, 4'd1};
  localparam logic [23:0] SRC_MONO  = {4'd3, 4'd0, 4'd4, 4'd5, 4'd1, 4'd2};
  localparam logic [47:0] SRC_MULTI = {4'd9, 4'd6, 4'd3, 4'd0, 4'd10, 4'd11,
                                       4'd7, 4'd8, 4'd4, 4'd5, 4'd1, 4'd2};

  wdlbr_pkg::fmt_e fmt_q;
  logic [7:0]      group_q [wdlbr_pkg::GroupMax];
  int              fill_q;
  int              errs;
  lpcm_byte_t      expected_bytes_q [$];

  function automatic int group_len(wdlbr_pkg::fmt_e f);
    unique case (f)
      wdlbr_pkg::FMT_16:       return 2;
      wdlbr_pkg::FMT_24_MONO:  return 6;
      wdlbr_pkg::FMT_24_MULTI: return 12;
      default:                 return 1;
    endcase
  endfunction

  function automatic int src_slot(wdlbr_pkg::fmt_e f, int k);
    unique case (f)
      wdlbr_pkg::FMT_16:       return int'(SRC_16[k*4 +: 4]);
      wdlbr_pkg::FMT_24_MONO:  return int'(SRC_MONO[k*4 +: 4]);
      wdlbr_pkg::FMT_24_MULTI: return int'(SRC_MULTI[k*4 +: 4]);
      default:                 return 0;
    endcase
  endfunction

  // collect one byte, queue the bytes it releases
  function automatic void reorder_byte(logic [7:0] b, logic last_in);
    int         gsz;
    lpcm_byte_t r;
    gsz = group_len(fmt_q);
    if (fill_q >= gsz) fill_q = 0;
    group_q[fill_q] = b;
    fill_q++;
    if (fill_q == gsz) begin
      for (int k = 0; k < gsz; k++) begin
        r.data        = group_q[src_slot(fmt_q, k)];
        r.run_last    = (k == gsz - 1);
        r.stream_last = (k == gsz - 1) && last_in;
        r.unswapped   = 1'b0;
        expected_bytes_q.push_back(r);
      end
      fill_q = 0;
    end else if (last_in) begin
      // partial group flushed in arrival order
      for (int k = 0; k < fill_q; k++) begin
        r.data        = group_q[k];
        r.run_last    = (k == fill_q - 1);
        r.stream_last = (k == fill_q - 1);
        r.unswapped   = 1'b1;
        expected_bytes_q.push_back(r);
      end
      fill_q = 0;
    end
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      errs++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    lpcm_byte_t want;
    if (!rst_ni) begin
      fmt_q  = wdlbr_pkg::FMT_PASS;
      fill_q = 0;
      errs   = 0;
      expected_bytes_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_bytes_q.size() == 0) begin
          $display("%0t: unexpected out_byte %0h expected none", $time, out_byte_i);
          errs++;
        end else begin
          want = expected_bytes_q.pop_front();
          check_field("out_byte", int'(want.data), int'(out_byte_i));
          check_field("run_last", int'(want.run_last), int'(run_last_i));
          check_field("stream_last", int'(want.stream_last), int'(stream_last_i));
          check_field("unswapped", int'(want.unswapped), int'(unswapped_i));
        end
      end
      if (cfg_we_i) begin
        fmt_q  = wdlbr_pkg::fmt_e'(cfg_wdata_i);
        fill_q = 0;
      end
      if (in_valid_i && !in_stall_i) reorder_byte(in_byte_i, stream_end_i);
    end
    err_count_o <= errs;
    pending_o   <= expected_bytes_q.size();
  end

endmodule

// ----- test/wav_to_dvd_lpcm_byte_reorder_tb.sv -----
// testbench top: stimulus, idling and verdict for the wav to dvd lpcm byte reorder
`timescale 1ns / 1ps

module wav_to_dvd_lpcm_byte_reorder_tb;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we;
  logic [1:0] cfg_wdata;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_byte;
  logic       stream_end;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic       run_last;
  logic       stream_last;
  logic       unswapped;

  int err_count;
  int pending;

  // idling odds in percent, changed per idling mode
  int send_idle_pct = 13;
  int recv_idle_pct = 77;
  // request for one long receiver hold-off
  bit hold_req = 1'b0;

  wav_to_dvd_lpcm_byte_reorder i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .in_byte_i     (in_byte),
    .stream_end_i  (stream_end),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .out_byte_o    (out_byte),
    .run_last_o    (run_last),
    .stream_last_o (stream_last),
    .unswapped_o   (unswapped)
  );

  lpcm_order_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .in_byte_i     (in_byte),
    .stream_end_i  (stream_end),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .out_byte_i    (out_byte),
    .run_last_i    (run_last),
    .stream_last_i (stream_last),
    .unswapped_i   (unswapped),
    .err_count_o   (err_count),
    .pending_o     (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // hard stop well past the slowest legal run
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // receiver: random stall, plus one long hold-off on request so the block backs up
  initial begin : receiver
    int hold_left;
    bit hold_seen;
    hold_left = 0;
    hold_seen = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_seen) begin
        hold_seen = 1'b1;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  function automatic int bytes_per_group(wdlbr_pkg::fmt_e f);
    unique case (f)
      wdlbr_pkg::FMT_16:       return 2;
      wdlbr_pkg::FMT_24_MONO:  return 6;
      wdlbr_pkg::FMT_24_MULTI: return 12;
      default:                 return 1;
    endcase
  endfunction

  // one input transfer, with optional idle cycles ahead of it
  task automatic send_byte(input logic [7:0] b, input logic last_in);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid   <= 1'b1;
    in_byte    <= b;
    stream_end <= last_in;
    // transfer happens at the first edge without stall
    do @(posedge clk_i); while (in_stall);
  endtask

  // wait until every expected byte has left the block
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // format writes only with the block idle; a partial group in the collector is dropped
  task automatic set_format(input wdlbr_pkg::fmt_e f);
    drain();
    repeat (4) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= f;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  task automatic directed_items();
    set_format(wdlbr_pkg::FMT_PASS);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b1);
    set_format(wdlbr_pkg::FMT_16);
    send_byte(8'ha5, 1'b0);
    send_byte(8'h5a, 1'b0);
    // partial group at stream end goes out unswapped
    send_byte(8'h3c, 1'b1);
    // complete pair at stream end
    send_byte(8'h80, 1'b0);
    send_byte(8'h7f, 1'b1);
    set_format(wdlbr_pkg::FMT_24_MONO);
    for (int k = 0; k < 6; k++) send_byte(8'(8'h10 + k), k == 5);
    // two bytes left in the collector, then a format change drops them
    send_byte(8'h21, 1'b0);
    send_byte(8'h22, 1'b0);
    set_format(wdlbr_pkg::FMT_24_MULTI);
    for (int k = 0; k < 12; k++) send_byte(8'(8'h30 + k), k == 11);
    send_byte(8'he7, 1'b1);
  endtask

  // mostly whole groups with random data, some broken runs with random stream ends
  task automatic random_items(input wdlbr_pkg::fmt_e f, input int count);
    int left;
    int gsz;
    int n;
    left = count;
    gsz  = bytes_per_group(f);
    while (left > 0) begin
      if ($urandom_range(99) < 80) begin
        n = gsz * $urandom_range(1, 3);
        for (int k = 0; k < n; k++)
          send_byte(8'($urandom), (k == n - 1) && ($urandom_range(1) == 1));
      end else begin
        n = $urandom_range(1, gsz);
        for (int k = 0; k < n; k++)
          send_byte(8'($urandom), $urandom_range(99) < 30);
      end
      left -= n;
    end
  endtask

  initial begin : stimulus
    int base;
    wdlbr_pkg::fmt_e f;
    rst_ni     <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_wdata  <= wdlbr_pkg::FMT_PASS;
    in_valid   <= 1'b0;
    in_byte    <= 8'h00;
    stream_end <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed_items();

    // idling modes: sender light and receiver heavy, then reversed, then none
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin send_idle_pct = 13; recv_idle_pct = 77; end
        1: begin send_idle_pct = 77; recv_idle_pct = 13; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      base = $urandom_range(3);
      for (int ph = 0; ph < 4; ph++) begin
        f = wdlbr_pkg::fmt_e'((base + ph) % 4);
        set_format(f);
        // long hold-off while the sender keeps offering
        if (mode == 2 && ph == 1) hold_req = 1'b1;
        random_items(f, 18);
      end
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (err_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/wdlbr_pkg.sv
sv/wdlbr_emit.sv
sv/wav_to_dvd_lpcm_byte_reorder.sv
sv/wdlbr_checker.sv
test/lpcm_order_checker.sv
test/wav_to_dvd_lpcm_byte_reorder_tb.sv
